@@ rtl/piex_pkg.sv @@
// Shared types and constants for the integer execute core.
// No dependencies; imported by piex_alu and powerpc_integer_execute_core.
package piex_pkg;

    localparam int PIEX_REG_COUNT = 32;
    localparam int XLEN           = 64;
    localparam int CR_WIDTH       = 32;
    localparam int IMM_WIDTH      = 26;

    // CR0 field codes (bits 31..28 of the condition register)
    localparam logic [3:0] CR0_LT = 4'h8;
    localparam logic [3:0] CR0_GT = 4'h4;
    localparam logic [3:0] CR0_EQ = 4'h2;

    localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

    // Operation codes; 8..15 are unsupported
    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_ADDI   = 4'd1,
        OP_ADD    = 4'd2,
        OP_SUBF   = 4'd3,
        OP_OR     = 4'd4,
        OP_AND    = 4'd5,
        OP_XOR    = 4'd6,
        OP_BRANCH = 4'd7
    } t_op;

    // Operation result and state updates produced by the ALU
    typedef struct packed {
        logic                status;
        logic                writes;
        logic [XLEN-1:0]     res;
        logic [XLEN-1:0]     next_pc;
        logic [CR_WIDTH-1:0] next_cr;
        logic                lr_we;
        logic [XLEN-1:0]     lr_val;
    } t_exec_res;

endpackage

@@ rtl/piex_ram.sv @@
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module piex_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/piex_alu.sv @@
// Combinational execute logic: result, next PC, CR0 update, link update.
// Depends on piex_pkg.
module piex_alu
    import piex_pkg::*;
(
    input  logic [3:0]                 i_op,
    input  logic [XLEN-1:0]            i_a,
    input  logic [XLEN-1:0]            i_b,
    input  logic                       i_ra_zero,
    input  logic signed [IMM_WIDTH-1:0] i_imm,
    input  logic                       i_rec,
    input  logic                       i_abs,
    input  logic                       i_lnk,
    input  logic [XLEN-1:0]            i_pc,
    input  logic [CR_WIDTH-1:0]        i_cr,
    output t_exec_res                  o_ex
);

    logic [XLEN-1:0] imm_ext;
    logic [XLEN-1:0] pc_inc;
    logic [3:0]      cr0;

    assign imm_ext = XLEN'(i_imm);
    assign pc_inc  = i_pc + PC_STEP;

    always_comb begin
        o_ex.status  = 1'b0;
        o_ex.writes  = 1'b0;
        o_ex.res     = '0;
        o_ex.next_pc = i_pc;
        o_ex.next_cr = i_cr;
        o_ex.lr_we   = 1'b0;
        o_ex.lr_val  = pc_inc;
        unique case (i_op)
            OP_NOP:  o_ex.next_pc = pc_inc;
            OP_ADDI: begin
                o_ex.res    = (i_ra_zero ? '0 : i_a) + imm_ext;
                o_ex.writes = 1'b1;
            end
            OP_ADD: begin
                o_ex.res    = i_a + i_b;
                o_ex.writes = 1'b1;
            end
            OP_SUBF: begin
                o_ex.res    = i_b - i_a;
                o_ex.writes = 1'b1;
            end
            OP_OR: begin
                o_ex.res    = i_a | i_b;
                o_ex.writes = 1'b1;
            end
            OP_AND: begin
                o_ex.res    = i_a & i_b;
                o_ex.writes = 1'b1;
            end
            OP_XOR: begin
                o_ex.res    = i_a ^ i_b;
                o_ex.writes = 1'b1;
            end
            OP_BRANCH: begin
                if (i_abs) begin
                    o_ex.status = 1'b1;
                end else begin
                    o_ex.lr_we   = i_lnk;
                    o_ex.next_pc = i_pc + imm_ext;
                end
            end
            default: o_ex.status = 1'b1;
        endcase
        if (o_ex.writes) begin
            o_ex.next_pc = pc_inc;
        end

        // signed compare of the result against zero
        priority if (o_ex.res[XLEN-1]) begin
            cr0 = CR0_LT;
        end else if (o_ex.res != '0) begin
            cr0 = CR0_GT;
        end else begin
            cr0 = CR0_EQ;
        end

        if (o_ex.writes && i_rec && (i_op != OP_ADDI)) begin
            o_ex.next_cr = {cr0, i_cr[CR_WIDTH-5:0]};
        end
    end

endmodule

@@ rtl/powerpc_integer_execute_core.sv @@
// Top level of the integer execute core: request pipeline, register file, state.
// Depends on piex_pkg, piex_ram and piex_alu.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one decoded instruction
//   per request. Output channel (o_out_valid / i_out_ready) returns one result
//   per request: status, next PC, written value and the condition register.
// Pipeline: an accepted request is registered into the execute stage, and
//   the register file read is registered at acceptance too; the ALU then
//   works between that stage and the output register, which drives the
//   output ports.
// Throughput: one request per cycle, limited by nothing but the output
//   handshake. A result written by one request is forwarded to the next one
//   when the register file read happened in the same edge as the write.
// Reset: i_rst_n low clears PC, CR, LR, both pipeline valids and the
//   per-register valid bits; a register never written since reset reads zero.
// Stall: while the output is full and not taken, the execute stage holds its
//   request, and a new request is taken only when the execute stage is empty
//   or moves its request to the output in the same cycle.
module powerpc_integer_execute_core
    import piex_pkg::*;
#(
    parameter int  REG_COUNT = PIEX_REG_COUNT,
    localparam int REG_AW    = $clog2(REG_COUNT)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [3:0]                  i_operation,
    input  logic [REG_AW-1:0]           i_dest_reg,
    input  logic [REG_AW-1:0]           i_src_a_reg,
    input  logic [REG_AW-1:0]           i_src_b_reg,
    input  logic signed [IMM_WIDTH-1:0] i_immediate,
    input  logic                        i_record_flag,
    input  logic                        i_absolute_flag,
    input  logic                        i_link_flag,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_status,
    output logic [XLEN-1:0]             o_next_pc,
    output logic [XLEN-1:0]             o_written_value,
    output logic [CR_WIDTH-1:0]         o_condition_value
);

    // architectural state
    logic [XLEN-1:0]     r_pc;
    logic [CR_WIDTH-1:0] r_cr;
    logic [XLEN-1:0]     r_lr;
    logic [REG_COUNT-1:0] r_gpr_valid;   // cleared at reset: unwritten regs read 0

    // execute stage
    logic                        r_s1_v;
    logic [3:0]                  r_op;
    logic [REG_AW-1:0]           r_rt;
    logic                        r_ra_zero;
    logic signed [IMM_WIDTH-1:0] r_imm;
    logic                        r_rec;
    logic                        r_abs;
    logic                        r_lnk;
    logic                        r_va;
    logic                        r_vb;
    logic                        r_fwd_a;
    logic                        r_fwd_b;
    logic [XLEN-1:0]             r_fwd_val;

    // output register
    logic                r_out_v;
    logic                r_status;
    logic [XLEN-1:0]     r_next_pc;
    logic [XLEN-1:0]     r_wval;
    logic [CR_WIDTH-1:0] r_out_cr;

    logic            out_free;
    logic            s1_adv;
    logic            in_acc;
    logic            wb_en;
    logic [XLEN-1:0] ram_a;
    logic [XLEN-1:0] ram_b;
    logic [XLEN-1:0] opnd_a;
    logic [XLEN-1:0] opnd_b;
    t_exec_res       ex;

    assign out_free   = !r_out_v || i_out_ready;
    assign s1_adv     = r_s1_v && out_free;
    assign o_in_ready = !r_s1_v || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign wb_en      = s1_adv && ex.writes;

    piex_ram #(
        .WIDTH (XLEN),
        .DEPTH (REG_COUNT)
    ) u_gpr (
        .i_clk     (i_clk),
        .i_we      (wb_en),
        .i_waddr   (r_rt),
        .i_wdata   (ex.res),
        .i_re      (in_acc),
        .i_raddr_a (i_src_a_reg),
        .i_raddr_b (i_src_b_reg),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // operand select: forwarded write-back, RAM data, or zero if never written
    assign opnd_a = r_fwd_a ? r_fwd_val : (r_va ? ram_a : '0);
    assign opnd_b = r_fwd_b ? r_fwd_val : (r_vb ? ram_b : '0);

    piex_alu u_alu (
        .i_op      (r_op),
        .i_a       (opnd_a),
        .i_b       (opnd_b),
        .i_ra_zero (r_ra_zero),
        .i_imm     (r_imm),
        .i_rec     (r_rec),
        .i_abs     (r_abs),
        .i_lnk     (r_lnk),
        .i_pc      (r_pc),
        .i_cr      (r_cr),
        .o_ex      (ex)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_out_v     <= 1'b0;
            r_pc        <= '0;
            r_cr        <= '0;
            r_lr        <= '0;
            r_gpr_valid <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_v <= i_in_valid;
            end
            if (out_free) begin
                r_out_v <= r_s1_v;
            end
            if (s1_adv) begin
                r_pc <= ex.next_pc;
                r_cr <= ex.next_cr;
                if (ex.lr_we) begin
                    r_lr <= ex.lr_val;
                end
            end
            if (wb_en) begin
                r_gpr_valid[r_rt] <= 1'b1;
            end
        end
    end

    // execute stage payload; forward flags catch a write-back in the same edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op      <= i_operation;
            r_rt      <= i_dest_reg;
            r_ra_zero <= (i_src_a_reg == '0);
            r_imm     <= i_immediate;
            r_rec     <= i_record_flag;
            r_abs     <= i_absolute_flag;
            r_lnk     <= i_link_flag;
            r_va      <= r_gpr_valid[i_src_a_reg];
            r_vb      <= r_gpr_valid[i_src_b_reg];
            r_fwd_a   <= wb_en && (r_rt == i_src_a_reg);
            r_fwd_b   <= wb_en && (r_rt == i_src_b_reg);
            r_fwd_val <= ex.res;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_status  <= ex.status;
            r_next_pc <= ex.next_pc;
            r_wval    <= ex.writes ? ex.res : '0;
            r_out_cr  <= ex.next_cr;
        end
    end

    assign o_out_valid       = r_out_v;
    assign o_status          = r_status;
    assign o_next_pc         = r_next_pc;
    assign o_written_value   = r_wval;
    assign o_condition_value = r_out_cr;

endmodule
